// File: src/signed_int_to_decimal_ascii_unit_defines.svh
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII: assertion macros
// Shared helpers for the concurrent checks on the unit's ports.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define SIDAU_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define SIDAU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: src/sidau_pkg.sv
// ----------------------------------------------------------------------------
// sidau_pkg
// Types and constants shared by the decimal ASCII conversion unit.
// ----------------------------------------------------------------------------
package sidau_pkg;

	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'd45;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_SIGN,
		ST_EMIT
	} sidau_state_t;

	// sequencer -> shared BCD unit
	typedef struct packed {
		logic load;
		logic dabble;
		logic shift_digit;
	} sidau_cmd_t;

	// shared BCD unit -> sequencer
	typedef struct packed {
		logic       neg;
		logic [3:0] digit;
	} sidau_status_t;

	// sequencer -> output register
	typedef struct packed {
		logic valid;
		logic minus;
		logic last;
	} sidau_emit_t;

	// decimal digits of 2^(w-1), the largest magnitude at width w (elaboration only)
	function automatic int digits_for_width(input int w);
		longint unsigned v;
		int              n;
		v = longint'(1) << (w - 1);
		n = 0;
		do begin
			n = n + 1;
			v = v / 10;
		end while (v != 0);
		return n;
	endfunction

endpackage

// File: src/sidau_dabble.sv
// ----------------------------------------------------------------------------
// sidau_dabble
// Shared shift-and-add-3 unit: magnitude to BCD, then digit shift-out.
// ----------------------------------------------------------------------------
module sidau_dabble
	import sidau_pkg::*;
#(
	parameter int INPUT_WIDTH = 32
) (
	input  logic                          clk,
	input  logic signed [INPUT_WIDTH-1:0] value,
	input  sidau_cmd_t                    cmd,
	output sidau_status_t                 status
);

	localparam int DIGITS = digits_for_width(INPUT_WIDTH);
	localparam int BCD_W  = 4 * DIGITS;

	logic [INPUT_WIDTH-1:0] raw;
	logic [INPUT_WIDTH-1:0] mag;
	logic [INPUT_WIDTH-1:0] bin_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BCD_W-1:0]       adj;
	logic                   neg_q;

	// two's complement negate at full width: the most negative value lands on 2^(W-1)
	assign raw = value;
	assign mag = raw[INPUT_WIDTH-1] ? (~raw + INPUT_WIDTH'(1)) : raw;

	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? (bcd_q[4*i +: 4] + 4'd3)
			                                          : bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= mag;
			bcd_q <= '0;
			neg_q <= raw[INPUT_WIDTH-1];
		end else if (cmd.dabble) begin
			bcd_q <= {adj[BCD_W-2:0], bin_q[INPUT_WIDTH-1]};
			bin_q <= {bin_q[INPUT_WIDTH-2:0], 1'b0};
		end else if (cmd.shift_digit) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
		end
	end

	assign status.neg   = neg_q;
	assign status.digit = bcd_q[BCD_W-1 -: 4];

endmodule

// File: src/sidau_seq.sv
// ----------------------------------------------------------------------------
// sidau_seq
// Sequencer: load, W dabble steps, optional sign, digit scan with zero skip.
// ----------------------------------------------------------------------------
module sidau_seq
	import sidau_pkg::*;
#(
	parameter int INPUT_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  sidau_status_t status,
	output logic          busy,
	output sidau_cmd_t    cmd,
	output sidau_emit_t   emit
);

	localparam int DIGITS    = digits_for_width(INPUT_WIDTH);
	localparam int BIT_CNT_W = $clog2(INPUT_WIDTH + 1);
	localparam int DIG_CNT_W = $clog2(DIGITS + 1);

	sidau_state_t         state_q;
	sidau_state_t         state_d;
	logic [BIT_CNT_W-1:0] bit_cnt_q;
	logic [DIG_CNT_W-1:0] dig_cnt_q;
	logic                 seen_q;
	logic                 is_last;
	logic                 skip;

	assign is_last = (dig_cnt_q == DIG_CNT_W'(1));
	// leading zeros dropped, but the units digit always goes out
	assign skip    = !seen_q && (status.digit == 4'd0) && !is_last;
	assign busy    = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_CONVERT;
			end
			ST_CONVERT: begin
				if (bit_cnt_q == BIT_CNT_W'(1)) state_d = status.neg ? ST_SIGN : ST_EMIT;
			end
			ST_SIGN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (is_last) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		emit = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = start;
			end
			ST_CONVERT: begin
				cmd.dabble = 1'b1;
			end
			ST_SIGN: begin
				emit.valid = 1'b1;
				emit.minus = 1'b1;
			end
			ST_EMIT: begin
				cmd.shift_digit = 1'b1;
				emit.valid      = !skip;
				emit.last       = is_last;
			end
			default: begin
				cmd  = '0;
				emit = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
			seen_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				bit_cnt_q <= BIT_CNT_W'(INPUT_WIDTH);
				dig_cnt_q <= DIG_CNT_W'(DIGITS);
				seen_q    <= 1'b0;
			end else begin
				if (cmd.dabble) bit_cnt_q <= bit_cnt_q - BIT_CNT_W'(1);
				if (cmd.shift_digit) begin
					dig_cnt_q <= dig_cnt_q - DIG_CNT_W'(1);
					seen_q    <= seen_q | (status.digit != 4'd0);
				end
			end
		end
	end

endmodule

// File: src/signed_int_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Signed integer to decimal ASCII text, one character per strobe.
// ----------------------------------------------------------------------------
// A transaction starts when start is high while busy is low; value is taken
// on that edge and busy stays high until the last digit has been issued.
// Characters come out most significant first on char_code, each for exactly
// one cycle with strobe high: a '-' first for negative values, then the
// digits with no leading zeros (zero gives a single '0'). last_char marks
// the final character. The receiver cannot stall the unit, so it must take
// every strobed character. The most negative value converts exactly.
// Sequence: a shift-and-add-3 binary to BCD pass, one bit per cycle through
// the shared unit; a sign step for a negative value; then the digit scan,
// one BCD digit per cycle over D positions, where D is the digit count of
// 2^(INPUT_WIDTH-1) (10 at 32 bits), with skipped leading zeros still
// taking their scan step. busy drops after the scan, and only then is the
// next start taken. Each character appears on the ports in the cycle after
// the step that produced it.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit
	import sidau_pkg::*;
#(
	parameter int INPUT_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [INPUT_WIDTH-1:0] value,
	output logic                          strobe,
	output logic [7:0]                    char_code,
	output logic                          last_char
);

	sidau_cmd_t    cmd;
	sidau_status_t status;
	sidau_emit_t   emit;

	logic          strobe_q;
	logic [7:0]    char_code_q;
	logic          last_char_q;

	// shared BCD datapath: holds magnitude, sign and digit register
	sidau_dabble #(
		.INPUT_WIDTH (INPUT_WIDTH)
	) u_dabble (
		.clk    (clk),
		.value  (value),
		.cmd    (cmd),
		.status (status)
	);

	// control: bit and digit counters, zero suppression
	sidau_seq #(
		.INPUT_WIDTH (INPUT_WIDTH)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.busy   (busy),
		.cmd    (cmd),
		.emit   (emit)
	);

	// strobe is control and resets; character payload does not
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			char_code_q <= emit.minus ? CHAR_MINUS : (CHAR_ZERO + {4'd0, status.digit});
			last_char_q <= emit.last;
		end
	end

	assign strobe    = strobe_q;
	assign char_code = char_code_q;
	assign last_char = last_char_q;

endmodule

// File: src/sidau_checker.sv
// ----------------------------------------------------------------------------
// sidau_checker
// Port-level checks on the conversion unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_unit_defines.svh"

module sidau_checker
	import sidau_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       strobe,
	input logic [7:0] char_code,
	input logic       last_char
);

	logic is_digit;

	// decimal digit on the character port
	assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_ZERO + 8'd9);

	// only '-' or a decimal digit ever goes out
	`SIDAU_ASSERT_SAME(a_char_set, strobe, (char_code == CHAR_MINUS) || is_digit)

	// a sign is never the end of a number
	`SIDAU_ASSERT_SAME(a_minus_not_last, strobe && (char_code == CHAR_MINUS), !last_char)

	// mid-number characters only while the transaction still holds busy
	`SIDAU_ASSERT_SAME(a_busy_mid_text, strobe && !last_char, busy)

	// nothing follows the final character straight away
	`SIDAU_ASSERT_NEXT(a_gap_after_last, strobe && last_char, !strobe)

	// an accepted start occupies the unit
	`SIDAU_ASSERT_NEXT(a_start_busy, start && !busy, busy)

endmodule

bind signed_int_to_decimal_ascii_unit sidau_checker u_sidau_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.strobe    (strobe),
	.char_code (char_code),
	.last_char (last_char)
);

// File: tb/tb_signed_int_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii_unit
// Self-checking bench for the signed integer to decimal ASCII unit: drives
// values through the start/busy handshake, predicts the character stream of
// each transaction and compares every strobed character in order.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import sidau_pkg::CHAR_ZERO;
	import sidau_pkg::CHAR_MINUS;

	localparam int VALUE_W = 32;
	localparam int ITEMS_PER_PHASE = 140;

	// one expected character of the decimal text
	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} ascii_char_t;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic signed [VALUE_W-1:0] value;
	logic                      strobe;
	logic [7:0]                char_code;
	logic                      last_char;

	// characters still owed by the unit, oldest first
	ascii_char_t expected_text[$];
	int          fail_count = 0;

	signed_int_to_decimal_ascii_unit #(
		.INPUT_WIDTH(VALUE_W)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.strobe    (strobe),
		.char_code (char_code),
		.last_char (last_char)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop. The slowest legal run is roughly 450 transactions plus sender
	// gaps, well under 160 us.
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Prediction: decimal text of one value, appended to expected_text.
	// Magnitude is taken one bit wider so the most negative value is exact.
	// ------------------------------------------------------------------------
	function automatic void predict_decimal_text(input logic signed [VALUE_W-1:0] v);
		logic [VALUE_W:0] magnitude;
		logic [3:0]       digit_buf[24];
		int               n_digits;
		ascii_char_t      c;
		magnitude = v[VALUE_W-1] ? ({(VALUE_W+1){1'b0}} - {v[VALUE_W-1], v}) : {1'b0, v};
		n_digits  = 0;
		do begin
			digit_buf[n_digits] = 4'(magnitude % 10);
			magnitude           = magnitude / 10;
			n_digits++;
		end while (magnitude != 0);
		if (v[VALUE_W-1]) begin
			c.code = CHAR_MINUS;
			c.last = 1'b0;
			expected_text.push_back(c);
		end
		for (int i = n_digits - 1; i >= 0; i--) begin
			c.code = CHAR_ZERO + 8'(digit_buf[i]);
			c.last = (i == 0);
			expected_text.push_back(c);
		end
	endfunction

	// ------------------------------------------------------------------------
	// Character checker: every strobe must match the oldest expectation.
	// Outputs are sampled at the rising edge, before the unit updates them.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		ascii_char_t want;
		if (arst_n && strobe !== 1'b0) begin
			if (strobe !== 1'b1) begin
				$error("strobe: expected 0 or 1, actual %b", strobe);
				fail_count++;
			end else if (expected_text.size() == 0) begin
				$error("char_code: expected none, actual %0d (unexpected character)",
					char_code);
				fail_count++;
			end else begin
				want = expected_text.pop_front();
				if (char_code !== want.code) begin
					$error("char_code: expected %0d, actual %0d", want.code, char_code);
					fail_count++;
				end
				if (last_char !== want.last) begin
					$error("last_char: expected %0d, actual %0d", want.last, last_char);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// One transaction. Called and returns at a falling edge. Inputs move only
	// at falling edges; busy is stable there, so a high start with busy low
	// is certain to be taken at the next rising edge.
	// ------------------------------------------------------------------------
	task automatic send_value(input logic signed [VALUE_W-1:0] v, input int idle_pct);
		// sometimes let the unit finish first so the gap lands on the idle phase
		if (idle_pct > 0 && $urandom_range(0, 1) == 1) begin
			while (busy) @(negedge clk);
		end
		while ($urandom_range(0, 99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		value = v;
		start = 1'b1;
		while (busy) @(negedge clk);
		predict_decimal_text(v);
		@(negedge clk);
		start = 1'b0;
		value = $urandom; // junk while idle, must be ignored
	endtask

	// Sender holds off until the whole text has come out and the unit is idle.
	task automatic wait_text_drained();
		while (expected_text.size() != 0) @(negedge clk);
		while (busy) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic signed [VALUE_W-1:0] random_value();
		logic [VALUE_W-1:0] r;
		longint unsigned    p10;
		int unsigned        k;
		case ($urandom_range(0, 3))
			0: r = $urandom;
			1: begin
				// pick the digit count first so short numbers are common
				k   = $urandom_range(1, 10);
				p10 = 1;
				repeat (k) p10 = p10 * 10;
				r = VALUE_W'(64'($urandom) % p10);
			end
			2: r = $urandom_range(0, 20);
			default: begin
				k = $urandom_range(0, 15);
				case ($urandom_range(0, 2))
					0: r = 32'h7fff_ffff - k;
					1: r = 32'h8000_0000 + k;
					default: begin
						// around a power of ten, where the digit count steps
						p10 = 1;
						repeat ($urandom_range(1, 9)) p10 = p10 * 10;
						r = VALUE_W'(p10) + (k % 3) - 1;
					end
				endcase
			end
		endcase
		if ($urandom_range(0, 1) == 1) r = -r;
		return r;
	endfunction

	task automatic run_random_values(input int count, input int idle_pct);
		for (int i = 0; i < count; i++) begin
			send_value(random_value(), idle_pct);
			// occasional full pause mid-phase
			if ($urandom_range(0, 49) == 0) wait_text_drained();
		end
	endtask

	// ------------------------------------------------------------------------
	// Test tasks
	// ------------------------------------------------------------------------

	// Zero, single digits, digit-count steps, the extremes and bit patterns.
	task automatic test_edge_values();
		logic signed [VALUE_W-1:0] edge_vals[] = '{
			32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
			32'sd99, 32'sd100, 32'sd12345, -32'sd12345,
			32'sd999999999, 32'sd1000000000, -32'sd1000000000, 32'sd1000000001,
			32'sh7fff_ffff, 32'sh8000_0001, 32'sh8000_0000,
			32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0000_ffff, 32'shffff_0000
		};
		foreach (edge_vals[i]) send_value(edge_vals[i], 0);
		wait_text_drained();
	endtask

	// Light sender gaps: a 29 percent chance of each further idle step before a value.
	task automatic test_random_light_gaps();
		run_random_values(ITEMS_PER_PHASE, 29);
		wait_text_drained();
	endtask

	// Heavy sender gaps: a 65 percent chance of each further idle step before a value.
	task automatic test_random_heavy_gaps();
		run_random_values(ITEMS_PER_PHASE, 65);
		wait_text_drained();
	endtask

	// start held high whenever possible: next value taken as soon as busy drops.
	task automatic test_random_back_to_back();
		run_random_values(ITEMS_PER_PHASE, 0);
		wait_text_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		value  = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_edge_values();
		test_random_light_gaps();
		test_random_heavy_gaps();
		test_random_back_to_back();

		// let any stray character show up before judging
		repeat (50) @(negedge clk);
		if (fail_count == 0 && expected_text.size() == 0) begin
			$display("CHECK OK");
		end else begin
			if (expected_text.size() != 0)
				$error("char_code: expected %0d more characters, actual none",
					expected_text.size());
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
